// ===== sv/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants of the diagnostic command framer transmit buffer.
// ----------------------------------------------------------------------------
package dcf_pkg;

    localparam int BUF_LEN = 256;
    localparam int ADDR_W  = $clog2(BUF_LEN);
    localparam int PTR_W   = 9;

    typedef enum logic [2:0] {
        FUNC_TEXT_START = 3'd0,
        FUNC_TEXT_CHAR  = 3'd1,
        FUNC_TEXT_ARG   = 3'd2,
        FUNC_TEXT_END   = 3'd3,
        FUNC_CURSOR     = 3'd4,
        FUNC_CLEAR      = 3'd5,
        FUNC_POWER      = 3'd6,
        FUNC_TICK       = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TRUNC      = 3'd2,
        ST_BUSY       = 3'd3,
        ST_UNEXPECTED = 3'd4
    } status_t;

    localparam logic [7:0]  CMD_TEXT   = 8'h11;
    localparam logic [7:0]  CMD_CURSOR = 8'h12;
    localparam logic [7:0]  CMD_CLEAR  = 8'h13;
    localparam logic [7:0]  CMD_POWER  = 8'h14;
    localparam logic [15:0] POWER_MASK = 16'h7FFF;
    localparam logic [7:0]  CH_PERCENT = 8'h25;
    localparam logic [7:0]  CH_D       = 8'h64;
    localparam logic [7:0]  CH_U       = 8'h75;
    localparam logic [7:0]  CH_X       = 8'h78;
    localparam logic [7:0]  CH_L       = 8'h6C;

    typedef struct packed {
        logic             tx_valid;
        status_t          status;
        logic             sending;
        logic [PTR_W-1:0] fill_level;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        logic             seq_busy;
        logic [PTR_W-1:0] write_pos;
        logic [PTR_W-1:0] release_pos;
        logic [PTR_W-1:0] read_pos;
    } ptr_t;

endpackage

// ===== sv/dcf_buf_mem.sv =====
// ----------------------------------------------------------------------------
// dcf_buf_mem
// Byte buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dcf_buf_mem
    import dcf_pkg::*;
(
    input  logic              clk,
    input  wr_t               wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem_reg [BUF_LEN];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/dcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcf_ctrl
// Command decode, buffer pointers, text state and byte write sequencer.
// ----------------------------------------------------------------------------
module dcf_ctrl
    import dcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  func_t             func,
    input  logic [7:0]        char_byte,
    input  logic [31:0]       arg_value,
    input  logic [7:0]        cursor_row,
    input  logic [7:0]        cursor_col,
    input  logic [15:0]       power_level,
    input  logic              out_room,
    output logic              push,
    output res_t              res,
    output wr_t               wr,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output ptr_t              ptrs
);

    logic              enable_reg;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rel_reg, rel_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic              open_reg, open_next;
    logic              trunc_reg, trunc_next;
    logic              spec_reg, spec_next;
    logic [2:0]        pend_reg, pend_next;
    logic [1:0]        seq_cnt_reg, seq_cnt_next;
    logic [23:0]       seq_data_reg, seq_data_next;
    logic [ADDR_W-1:0] seq_addr_reg, seq_addr_next;

    logic              accept;
    logic [PTR_W-1:0]  free_bytes;
    logic [2:0]        nb;
    logic [31:0]       wbytes;
    logic [15:0]       lvl_m;
    status_t           st;
    logic              txv;

    assign in_ready   = (seq_cnt_reg == 2'd0) && out_room;
    assign accept     = in_valid && in_ready;
    assign push       = accept;
    assign free_bytes = PTR_W'(BUF_LEN) - wp_reg;
    assign lvl_m      = power_level & POWER_MASK;
    assign rd_addr    = rp_reg[ADDR_W-1:0];

    always_comb
    begin
        wp_next       = wp_reg;
        rel_next      = rel_reg;
        rp_next       = rp_reg;
        open_next     = open_reg;
        trunc_next    = trunc_reg;
        spec_next     = spec_reg;
        pend_next     = pend_reg;
        nb            = 3'd0;
        wbytes        = 32'd0;
        st            = ST_OK;
        txv           = 1'b0;
        rd_en         = 1'b0;
        seq_cnt_next  = seq_cnt_reg;
        seq_data_next = seq_data_reg;
        seq_addr_next = seq_addr_reg;
        wr.en         = 1'b0;
        wr.addr       = seq_addr_reg;
        wr.data       = seq_data_reg[7:0];

        if (seq_cnt_reg != 2'd0)
        begin
            wr.en         = 1'b1;
            seq_cnt_next  = seq_cnt_reg - 2'd1;
            seq_data_next = {8'd0, seq_data_reg[23:8]};
            seq_addr_next = seq_addr_reg + ADDR_W'(1);
        end

        if (accept)
        begin
            if (func == FUNC_TICK)
            begin
                if (rp_reg < rel_reg)
                begin
                    txv     = 1'b1;
                    rd_en   = 1'b1;
                    rp_next = rp_reg + PTR_W'(1);
                end
                if (rp_next == wp_reg)
                begin
                    rp_next  = '0;
                    wp_next  = '0;
                    rel_next = '0;
                end
            end
            else if (!enable_reg)
            begin
                st = ST_BUSY;
            end
            else if (func == FUNC_TEXT_START || func == FUNC_CURSOR ||
                     func == FUNC_CLEAR || func == FUNC_POWER)
            begin
                if (open_reg)
                begin
                    st = ST_BUSY;
                end
                else
                begin
                    case (func)
                        FUNC_TEXT_START:
                        begin
                            if (wp_reg >= PTR_W'(BUF_LEN))
                            begin
                                st = ST_NO_SPACE;
                            end
                            else
                            begin
                                nb         = 3'd1;
                                wbytes     = {24'd0, CMD_TEXT};
                                open_next  = 1'b1;
                                trunc_next = 1'b0;
                                spec_next  = 1'b0;
                                pend_next  = 3'd0;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            if (wp_reg >= PTR_W'(BUF_LEN - 1))
                            begin
                                st = ST_NO_SPACE;
                            end
                            else
                            begin
                                nb       = 3'd1;
                                wbytes   = {24'd0, CMD_CLEAR};
                                rel_next = wp_reg + PTR_W'(1);
                            end
                        end
                        default:
                        begin
                            if (wp_reg >= PTR_W'(BUF_LEN - 3))
                            begin
                                st = ST_NO_SPACE;
                            end
                            else
                            begin
                                nb       = 3'd3;
                                rel_next = wp_reg + PTR_W'(3);
                                if (func == FUNC_CURSOR)
                                begin
                                    wbytes = {8'd0, cursor_col, cursor_row, CMD_CURSOR};
                                end
                                else
                                begin
                                    wbytes = {8'd0, lvl_m[7:0], lvl_m[15:8], CMD_POWER};
                                end
                            end
                        end
                    endcase
                end
            end
            else if (!open_reg)
            begin
                st = ST_UNEXPECTED;
            end
            else
            begin
                case (func)
                    FUNC_TEXT_END:
                    begin
                        if (pend_reg != 3'd0)
                        begin
                            st = ST_UNEXPECTED;
                        end
                        else if (trunc_reg)
                        begin
                            st = ST_TRUNC;
                        end
                        open_next  = 1'b0;
                        trunc_next = 1'b0;
                        spec_next  = 1'b0;
                        pend_next  = 3'd0;
                        rel_next   = wp_reg;
                    end
                    FUNC_TEXT_CHAR:
                    begin
                        if (trunc_reg)
                        begin
                            st = ST_TRUNC;
                        end
                        else if (pend_reg != 3'd0)
                        begin
                            st = ST_UNEXPECTED;
                        end
                        else if (wp_reg >= PTR_W'(BUF_LEN))
                        begin
                            trunc_next = 1'b1;
                            spec_next  = 1'b0;
                            st         = ST_TRUNC;
                        end
                        else
                        begin
                            nb     = 3'd1;
                            wbytes = {24'd0, char_byte};
                            if (spec_reg)
                            begin
                                spec_next = 1'b0;
                                if (char_byte == CH_D || char_byte == CH_U ||
                                    char_byte == CH_X)
                                begin
                                    pend_next = 3'd2;
                                end
                                else if (char_byte == CH_L)
                                begin
                                    pend_next = 3'd4;
                                end
                            end
                            else if (char_byte == CH_PERCENT)
                            begin
                                spec_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (trunc_reg)
                        begin
                            st = ST_TRUNC;
                        end
                        else if (pend_reg == 3'd0)
                        begin
                            st = ST_UNEXPECTED;
                        end
                        else
                        begin
                            if (pend_reg == 3'd4)
                            begin
                                wbytes = {arg_value[7:0], arg_value[15:8],
                                          arg_value[23:16], arg_value[31:24]};
                            end
                            else
                            begin
                                wbytes = {16'd0, arg_value[7:0], arg_value[15:8]};
                            end
                            pend_next = 3'd0;
                            if (PTR_W'(pend_reg) > free_bytes)
                            begin
                                nb         = free_bytes[2:0];
                                trunc_next = 1'b1;
                                st         = ST_TRUNC;
                            end
                            else
                            begin
                                nb = pend_reg;
                            end
                        end
                    end
                endcase
            end

            if (func != FUNC_TICK)
            begin
                wp_next = wp_reg + PTR_W'(nb);
            end

            if (nb != 3'd0)
            begin
                wr.en         = 1'b1;
                wr.addr       = wp_reg[ADDR_W-1:0];
                wr.data       = wbytes[7:0];
                seq_cnt_next  = 2'(nb - 3'd1);
                seq_data_next = wbytes[31:8];
                seq_addr_next = wp_reg[ADDR_W-1:0] + ADDR_W'(1);
            end
        end

        res.tx_valid   = txv;
        res.status     = st;
        res.sending    = rp_next < rel_next;
        res.fill_level = wp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            wp_reg      <= '0;
            rel_reg     <= '0;
            rp_reg      <= '0;
            open_reg    <= 1'b0;
            trunc_reg   <= 1'b0;
            spec_reg    <= 1'b0;
            pend_reg    <= 3'd0;
            seq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            wp_reg      <= wp_next;
            rel_reg     <= rel_next;
            rp_reg      <= rp_next;
            open_reg    <= open_next;
            trunc_reg   <= trunc_next;
            spec_reg    <= spec_next;
            pend_reg    <= pend_next;
            seq_cnt_reg <= seq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_data_reg <= seq_data_next;
        seq_addr_reg <= seq_addr_next;
    end

    assign ptrs.seq_busy    = seq_cnt_reg != 2'd0;
    assign ptrs.write_pos   = wp_reg;
    assign ptrs.release_pos = rel_reg;
    assign ptrs.read_pos    = rp_reg;

endmodule

// ===== sv/dcf_out.sv =====
// ----------------------------------------------------------------------------
// dcf_out
// Result stage: joins read data to the result, then an output register.
// ----------------------------------------------------------------------------
module dcf_out
    import dcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_t       res,
    input  logic [7:0] rd_data,
    output logic       room,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_res,
    output logic [7:0] m_byte
);

    logic       p_valid_reg;
    res_t       p_res_reg;
    logic       o_valid_reg;
    res_t       o_res_reg;
    logic [7:0] o_byte_reg;
    logic       p_move;

    assign p_move = p_valid_reg && (!o_valid_reg || m_ready);
    assign room   = !p_valid_reg || p_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            p_res_reg <= res;
        end
        if (p_move)
        begin
            o_res_reg  <= p_res_reg;
            o_byte_reg <= p_res_reg.tx_valid ? rd_data : 8'd0;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_res   = o_res_reg;
    assign m_byte  = o_byte_reg;

endmodule

// ===== sv/diag_command_framer_tx_buffer.sv =====
// ----------------------------------------------------------------------------
// diag_command_framer_tx_buffer
// Results: a result beat passes a holding register, then the output register.
// Throughput: one beat per cycle; held while the output is full or a write burst runs.
// Reset: rst_n clears pointers, text state and enable; buffer bytes stay unwritten.
// ----------------------------------------------------------------------------
module diag_command_framer_tx_buffer
    import dcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // char_byte, arg_value, cursor_row, cursor_col,
                                        // power_level
    input  logic [2:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // tx_byte, status, sending, fill_level
    output logic        m_axis_tuser    // tx_valid
);

    logic              out_room;
    logic              push;
    res_t              res;
    wr_t               wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    ptr_t              ptrs;
    res_t              m_res;
    logic [7:0]        m_byte;

    dcf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .func        (func_t'(s_axis_tuser)),
        .char_byte   (s_axis_tdata[7:0]),
        .arg_value   (s_axis_tdata[39:8]),
        .cursor_row  (s_axis_tdata[47:40]),
        .cursor_col  (s_axis_tdata[55:48]),
        .power_level (s_axis_tdata[71:56]),
        .out_room    (out_room),
        .push        (push),
        .res         (res),
        .wr          (wr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .ptrs        (ptrs)
    );

    dcf_buf_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dcf_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .res     (res),
        .rd_data (rd_data),
        .room    (out_room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res),
        .m_byte  (m_byte)
    );

    assign m_axis_tdata = {3'd0, m_res.fill_level, m_res.sending, m_res.status, m_byte};
    assign m_axis_tuser = m_res.tx_valid;

`ifndef SYNTHESIS
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        ptrs.read_pos <= ptrs.release_pos && ptrs.release_pos <= ptrs.write_pos)
        else $error("buffer pointers out of order");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptrs.write_pos <= PTR_W'(BUF_LEN))
        else $error("write position beyond buffer");

    a_tick_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_res.status == ST_OK)
        else $error("sent byte with non-ok status");

    a_seq_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_CURSOR) &&
        !m_res.sending && $past(1'b1) |=> !ptrs.seq_busy || !s_axis_tready)
        else $error("beat accepted during buffer write burst");
`endif

endmodule
